// ===== hw/rtl/lwpb_pkg.sv =====
package lwpb_pkg;

	localparam int ENTRIES       = 8;
	localparam int FILE_ID_BITS  = 4;
	localparam int PAGE_NUM_BITS = 20;
	localparam int SLOT_BITS     = $clog2(ENTRIES);
	localparam int CNT_BITS      = $clog2(ENTRIES + 1);

	typedef logic [1:0]               mode_t;
	typedef logic [FILE_ID_BITS-1:0]  file_t;
	typedef logic [PAGE_NUM_BITS-1:0] page_t;
	typedef logic [SLOT_BITS-1:0]     slot_t;
	typedef logic [2:0]               kind_t;

	localparam mode_t MODE_READ   = 2'd0;
	localparam mode_t MODE_WRITE  = 2'd1;
	localparam mode_t MODE_CLOSE  = 2'd2;
	localparam mode_t MODE_UNUSED = 2'd3;

	localparam kind_t K_READ_HIT   = 3'd0;
	localparam kind_t K_WRITE_HIT  = 3'd1;
	localparam kind_t K_WRITEBACK  = 3'd2;
	localparam kind_t K_FILL       = 3'd3;
	localparam kind_t K_WALLOC     = 3'd4;
	localparam kind_t K_CLOSE_DONE = 3'd5;

	// Directory entry held in the tag memory
	typedef struct packed {
		file_t file;
		page_t page;
	} tag_t;

	typedef struct packed {
		kind_t kind;
		slot_t slot;
		file_t out_file;
		page_t out_page;
		logic  last;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_EVICT_RD,
		ST_CLOSE,
		ST_EMIT
	} state_t;

endpackage

// ===== hw/rtl/lwpb_req_if.sv =====
interface lwpb_req_if;
	import lwpb_pkg::*;
	logic  valid;
	logic  ready;
	mode_t mode;
	file_t file_id;
	page_t page_number;
	modport source (output valid, mode, file_id, page_number, input ready);
	modport sink (input valid, mode, file_id, page_number, output ready);
endinterface

// ===== hw/rtl/lwpb_res_if.sv =====
interface lwpb_res_if;
	import lwpb_pkg::*;
	logic  valid;
	logic  ready;
	kind_t kind;
	slot_t slot;
	file_t out_file;
	page_t out_page;
	logic  last;
	modport source (output valid, kind, slot, out_file, out_page, last, input ready);
	modport sink (input valid, kind, slot, out_file, out_page, last, output ready);
endinterface

// ===== hw/rtl/lwpb_tag_ram.sv =====
// Tag memory: one write port, one registered read port.
module lwpb_tag_ram
	import lwpb_pkg::*;
(
	input  logic  clk,
	input  logic  we,
	input  slot_t waddr,
	input  tag_t  wdata,
	input  slot_t raddr,
	output tag_t  rdata
);

	tag_t mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/lwpb_out_reg.sv =====
// Output register: holds one result transaction until taken.
module lwpb_out_reg
	import lwpb_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  res_t  data,
	output logic  full,
	lwpb_res_if.source res
);

	logic full_q;
	res_t data_q;

	// Hold until the sink accepts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (push) begin
			full_q <= 1'b1;
		end else if (res.ready) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= data;
		end
	end

	assign full         = full_q;
	assign res.valid    = full_q;
	assign res.kind     = data_q.kind;
	assign res.slot     = data_q.slot;
	assign res.out_file = data_q.out_file;
	assign res.out_page = data_q.out_page;
	assign res.last     = data_q.last;

endmodule

// ===== hw/rtl/lru_writeback_page_buffer_core.sv =====
// Fully associative 8-slot page buffer directory with LRU replacement and
// write-back marks. Tags sit in a synchronous memory with a registered read
// port; valid, dirty and rank bits live in flip-flops. One request is
// processed at a time and the request channel is ready only while the block
// is idle. A read or write scans the tags one slot per cycle, then decides
// and emits its result; a dirty eviction adds a tag read state and a second
// emit, the writeback ahead of the placement. A close walks the 8 ranks from
// the head, emits a writeback for each dirty slot of the file, then emits
// close-done. An unused mode is accepted and dropped. Every emit waits while
// the output register still holds a result that the sink has not taken.
module lru_writeback_page_buffer_core
	import lwpb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	lwpb_req_if.sink   req,
	lwpb_res_if.source res
);

	state_t state_q, state_d;

	logic [ENTRIES-1:0] valid_q, dirty_q;
	slot_t              rank_q [ENTRIES];

	mode_t   mode_q;
	file_t   file_q;
	page_t   page_q;
	logic [CNT_BITS-1:0] idx_q;
	logic [CNT_BITS-1:0] crank_q;
	logic    hit_q;
	slot_t   hit_slot_q;
	slot_t   cand_q;
	logic    found_q;
	slot_t   cand_rank_q;
	slot_t   pend_slot_q;
	logic    pend_s1;
	res_t    res_q;

	logic  ram_we;
	slot_t ram_waddr, ram_raddr;
	tag_t  ram_wdata, ram_rdata;

	logic out_full, out_push;

	lwpb_tag_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lwpb_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.data   (res_q),
		.full   (out_full),
		.res    (res)
	);

	logic  req_fire, out_free, evict_dirty, close_match;
	slot_t idx_slot, prev_slot, lru_slot, crank_slot, close_hit, sel_slot;
	res_t  place_res;

	assign req_fire    = req.valid && req.ready;
	assign out_free    = !out_full || res.ready;
	assign idx_slot    = idx_q[SLOT_BITS-1:0];
	assign prev_slot   = slot_t'(idx_q - 1'b1);
	assign crank_slot  = crank_q[SLOT_BITS-1:0];
	assign sel_slot    = hit_q ? hit_slot_q : (found_q ? cand_q : lru_slot);
	assign evict_dirty = !hit_q && !found_q && dirty_q[lru_slot];
	assign close_match = valid_q[pend_slot_q] && (ram_rdata.file == file_q);

	// Placement result that follows an eviction writeback
	assign place_res = '{kind: (mode_q == MODE_WRITE) ? K_WALLOC : K_FILL,
		slot: cand_q, out_file: file_q, out_page: page_q, last: 1'b1};

	// Find the LRU slot and the slot holding the current close rank
	always_comb begin
		lru_slot  = '0;
		close_hit = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (rank_q[i] == slot_t'(ENTRIES - 1)) begin
				lru_slot = slot_t'(i);
			end
			if (rank_q[i] == crank_slot) begin
				close_hit = slot_t'(i);
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					if (req.mode == MODE_CLOSE) begin
						state_d = ST_CLOSE;
					end else if (req.mode != MODE_UNUSED) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (idx_q == CNT_BITS'(ENTRIES)) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: state_d = evict_dirty ? ST_EVICT_RD : ST_EMIT;
			ST_EVICT_RD: state_d = ST_EMIT;
			ST_CLOSE: begin
				if (pend_s1) begin
					if (close_match && dirty_q[pend_slot_q]) begin
						state_d = ST_EMIT;
					end
				end else if (crank_q == CNT_BITS'(ENTRIES)) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					if (res_q.last) begin
						state_d = ST_IDLE;
					end else if (mode_q == MODE_CLOSE) begin
						state_d = ST_CLOSE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshakes and tag memory access
	always_comb begin
		req.ready = (state_q == ST_IDLE);
		out_push  = (state_q == ST_EMIT) && out_free;
		ram_we    = 1'b0;
		ram_waddr = sel_slot;
		ram_wdata = '{file: file_q, page: page_q};
		unique case (state_q)
			ST_CLOSE: ram_raddr = close_hit;
			ST_DECIDE: ram_raddr = lru_slot;
			default: ram_raddr = idx_slot;
		endcase
		if (state_q == ST_DECIDE && !hit_q && !evict_dirty) begin
			ram_we = 1'b1;
		end
		if (state_q == ST_EVICT_RD) begin
			ram_we    = 1'b1;
			ram_waddr = cand_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			dirty_q     <= '0;
			idx_q       <= '0;
			crank_q     <= '0;
			hit_q       <= 1'b0;
			hit_slot_q  <= '0;
			cand_q      <= '0;
			found_q     <= 1'b0;
			cand_rank_q <= '0;
			pend_slot_q <= '0;
			pend_s1     <= 1'b0;
			res_q       <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= slot_t'(i);
			end
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						idx_q   <= '0;
						crank_q <= '0;
						hit_q   <= 1'b0;
						found_q <= 1'b0;
						pend_s1 <= 1'b0;
					end
				end
				ST_SCAN: begin
					// Compare the tag read last cycle and track the fill candidate
					if (idx_q != '0) begin
						if (valid_q[prev_slot] && ram_rdata.file == file_q
							&& ram_rdata.page == page_q) begin
							hit_q      <= 1'b1;
							hit_slot_q <= prev_slot;
						end
						if (!valid_q[prev_slot] && (!found_q || rank_q[prev_slot] > cand_rank_q))
						begin
							found_q     <= 1'b1;
							cand_q      <= prev_slot;
							cand_rank_q <= rank_q[prev_slot];
						end
					end
					if (idx_q != CNT_BITS'(ENTRIES)) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DECIDE: begin
					// Apply hit or placement, update ranks
					for (int i = 0; i < ENTRIES; i++) begin
						if (rank_q[i] < rank_q[sel_slot]) begin
							rank_q[i] <= rank_q[i] + 1'b1;
						end
					end
					rank_q[sel_slot] <= '0;
					cand_q           <= sel_slot;
					if (hit_q) begin
						if (mode_q == MODE_WRITE) begin
							dirty_q[sel_slot] <= 1'b1;
						end
						res_q <= '{kind: (mode_q == MODE_WRITE) ? K_WRITE_HIT : K_READ_HIT,
							slot: sel_slot, out_file: file_q, out_page: page_q, last: 1'b1};
					end else begin
						valid_q[sel_slot] <= 1'b1;
						dirty_q[sel_slot] <= (mode_q == MODE_WRITE);
						res_q <= '{kind: (mode_q == MODE_WRITE) ? K_WALLOC : K_FILL,
							slot: sel_slot, out_file: file_q, out_page: page_q, last: 1'b1};
					end
				end
				ST_EVICT_RD: begin
					// Old tag arrives: send its writeback first
					res_q <= '{kind: K_WRITEBACK, slot: cand_q, out_file: ram_rdata.file,
						out_page: ram_rdata.page, last: 1'b0};
				end
				ST_CLOSE: begin
					// Walk ranks from head; one read in flight at a time
					if (pend_s1) begin
						pend_s1 <= 1'b0;
						if (close_match) begin
							if (dirty_q[pend_slot_q]) begin
								res_q <= '{kind: K_WRITEBACK, slot: pend_slot_q,
									out_file: file_q, out_page: ram_rdata.page, last: 1'b0};
							end
							valid_q[pend_slot_q] <= 1'b0;
							dirty_q[pend_slot_q] <= 1'b0;
						end
					end else if (crank_q == CNT_BITS'(ENTRIES)) begin
						res_q <= '{kind: K_CLOSE_DONE, slot: '0, out_file: file_q,
							out_page: '0, last: 1'b1};
					end else begin
						pend_slot_q <= close_hit;
						pend_s1     <= 1'b1;
						crank_q     <= crank_q + 1'b1;
					end
				end
				ST_EMIT: begin
					// Queue the placement once the eviction writeback leaves
					if (out_push && !res_q.last && mode_q != MODE_CLOSE) begin
						res_q <= place_res;
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			mode_q <= req.mode;
			file_q <= req.file_id;
			page_q <= req.page_number;
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
	import lwpb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int errors = 0;
	int idle_cycles = 0;

	lwpb_req_if req ();
	lwpb_res_if res ();

	lru_writeback_page_buffer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.res(res.source)
	);

	always #5 clk = ~clk;

	// Directory shadow
	logic  dir_valid [ENTRIES];
	file_t dir_file [ENTRIES];
	page_t dir_page [ENTRIES];
	logic  dir_dirty [ENTRIES];
	int    dir_rank [ENTRIES];
	res_t  expected_results [$];

	// Recently used pages, for hit-heavy random traffic
	file_t seen_file [$];
	page_t seen_page [$];

	task automatic shadow_reset();
		for (int i = 0; i < ENTRIES; i++) begin
			dir_valid[i] = 1'b0;
			dir_file[i] = '0;
			dir_page[i] = '0;
			dir_dirty[i] = 1'b0;
			dir_rank[i] = i;
		end
	endtask

	function automatic res_t make_res(kind_t k, int s, file_t f, page_t p, logic l);
		res_t r;
		r.kind = k;
		r.slot = slot_t'(s);
		r.out_file = f;
		r.out_page = p;
		r.last = l;
		return r;
	endfunction

	task automatic promote_slot(int s);
		int r;
		r = dir_rank[s];
		for (int i = 0; i < ENTRIES; i++)
			if (dir_rank[i] < r) dir_rank[i]++;
		dir_rank[s] = 0;
	endtask

	// Compute the results of one request and update the shadow
	task automatic predict_request(mode_t m, file_t f, page_t p);
		int best;
		int best_rank;
		int lru;
		bit found;
		if (m == MODE_UNUSED) return;
		if (m == MODE_CLOSE) begin
			for (int r = 0; r < ENTRIES; r++)
				for (int i = 0; i < ENTRIES; i++)
					if (dir_rank[i] == r && dir_valid[i] && dir_file[i] == f) begin
						if (dir_dirty[i])
							expected_results.push_back(make_res(K_WRITEBACK, i, dir_file[i],
								dir_page[i], 1'b0));
						dir_valid[i] = 1'b0;
						dir_dirty[i] = 1'b0;
					end
			expected_results.push_back(make_res(K_CLOSE_DONE, 0, f, '0, 1'b1));
			return;
		end
		for (int i = 0; i < ENTRIES; i++)
			if (dir_valid[i] && dir_file[i] == f && dir_page[i] == p) begin
				if (m == MODE_WRITE) dir_dirty[i] = 1'b1;
				promote_slot(i);
				expected_results.push_back(make_res(m == MODE_WRITE ? K_WRITE_HIT : K_READ_HIT,
					i, f, p, 1'b1));
				return;
			end
		found = 1'b0;
		best = 0;
		best_rank = 0;
		lru = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (!dir_valid[i] && (!found || dir_rank[i] > best_rank)) begin
				found = 1'b1;
				best = i;
				best_rank = dir_rank[i];
			end
			if (dir_rank[i] == ENTRIES - 1) lru = i;
		end
		if (!found) begin
			best = lru;
			if (dir_dirty[best])
				expected_results.push_back(make_res(K_WRITEBACK, best, dir_file[best],
					dir_page[best], 1'b0));
		end
		dir_valid[best] = 1'b1;
		dir_file[best] = f;
		dir_page[best] = p;
		dir_dirty[best] = (m == MODE_WRITE);
		promote_slot(best);
		expected_results.push_back(make_res(m == MODE_WRITE ? K_WALLOC : K_FILL, best, f, p,
			1'b1));
	endtask

	// Drive one transaction on the request channel
	task automatic send_request(mode_t m, file_t f, page_t p);
		int gap;
		gap = $urandom_range(0, 9);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.mode <= m;
		req.file_id <= f;
		req.page_number <= p;
		do @(posedge clk); while (!req.ready);
		predict_request(m, f, p);
		if (m != MODE_CLOSE) begin
			seen_file.push_back(f);
			seen_page.push_back(p);
			if (seen_file.size() > 12) begin
				void'(seen_file.pop_front());
				void'(seen_page.pop_front());
			end
		end
		@(negedge clk);
	endtask

	// Random result stalls
	initial begin
		int stall;
		res.ready = 1'b0;
		forever begin
			stall = $urandom_range(0, 9);
			if ($urandom_range(0, 3) == 0) stall = 0;
			@(negedge clk);
			if (stall > 0) begin
				res.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!res.valid);
		end
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			res_t want;
			if (expected_results.size() == 0) begin
				$error("unexpected result kind=%0d slot=%0d", res.kind, res.slot);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (res.kind !== want.kind) begin
					$error("kind exp %0d got %0d", want.kind, res.kind); errors++;
				end
				if (res.slot !== want.slot) begin
					$error("slot exp %0d got %0d", want.slot, res.slot); errors++;
				end
				if (res.out_file !== want.out_file) begin
					$error("out_file exp %0d got %0d", want.out_file, res.out_file); errors++;
				end
				if (res.out_page !== want.out_page) begin
					$error("out_page exp %0h got %0h", want.out_page, res.out_page); errors++;
				end
				if (res.last !== want.last) begin
					$error("last exp %0d got %0d", want.last, res.last); errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (res.valid && res.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	task automatic test_extremes();
		send_request(MODE_READ, 4'hF, 20'hFFFFF);
		send_request(MODE_WRITE, 4'h0, 20'h00000);
		send_request(MODE_READ, 4'hF, 20'hFFFFF);
		send_request(MODE_WRITE, 4'hF, 20'hFFFFF);
		send_request(MODE_UNUSED, 4'hA, 20'h55555);
		send_request(MODE_CLOSE, 4'h7, 20'hAAAAA);
	endtask

	// Fill, evict dirty and clean slots, close with several writebacks
	task automatic test_evict_and_close();
		for (int i = 0; i < 8; i++)
			send_request((i % 2) ? MODE_WRITE : MODE_READ, 4'h3, page_t'(i + 16));
		send_request(MODE_WRITE, 4'h3, 20'h00010);
		send_request(MODE_READ, 4'h5, 20'h12345);
		send_request(MODE_READ, 4'h5, 20'h54321);
		send_request(MODE_WRITE, 4'h5, 20'hAAAAA);
		send_request(MODE_CLOSE, 4'h3, 20'h0);
		send_request(MODE_CLOSE, 4'h3, 20'hFFFFF);
		send_request(MODE_READ, 4'h9, 20'h00001);
		send_request(MODE_CLOSE, 4'h5, 20'h0);
	endtask

	task automatic test_random(int count);
		mode_t m;
		file_t f;
		page_t p;
		int sel;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 99);
			m = ($urandom_range(0, 1) == 1) ? MODE_WRITE : MODE_READ;
			f = file_t'($urandom_range(0, 3));
			p = page_t'($urandom_range(0, 11));
			if (sel < 35 && seen_file.size() > 0) begin
				sel = $urandom_range(0, seen_file.size() - 1);
				f = seen_file[sel];
				p = seen_page[sel];
			end else if (sel < 45) begin
				f = file_t'($urandom);
				p = page_t'($urandom);
			end else if (sel < 55) begin
				m = MODE_CLOSE;
				p = page_t'($urandom);
			end else if (sel < 57) begin
				m = MODE_UNUSED;
			end
			send_request(m, f, p);
		end
	endtask

	initial begin
		req.valid = 1'b0;
		req.mode = MODE_READ;
		req.file_id = '0;
		req.page_number = '0;
		shadow_reset();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_extremes();
		test_evict_and_close();
		test_random(440);
		req.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) $display("tb_top OK");
		else $display("tb_top NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/lwpb_pkg.sv
hw/rtl/lwpb_req_if.sv
hw/rtl/lwpb_res_if.sv
hw/rtl/lwpb_tag_ram.sv
hw/rtl/lwpb_out_reg.sv
hw/rtl/lru_writeback_page_buffer_core.sv
tb/sv/tb_top.sv
